/* src/bbtb_pkg.sv */
// Shared types, constants and codes of the bounding box tree builder.
package bbtb_pkg;

  // Fixed field geometry.
  localparam int NUM_DIMS = 4;
  localparam int COORD_W  = 32;
  localparam int GS_W     = 5;
  localparam int DIMS_W   = 3;
  localparam int LEVEL_W  = 4;
  localparam int INDEX_W  = 24;

  // Configuration port geometry.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_LEVELS_DEF = 8;
  localparam int MAX_GROUP_DEF  = 16;
  localparam int CMD_DEPTH_DEF  = 2;
  localparam int RES_DEPTH_DEF  = 4;

  // Clamp limits of the registers.
  localparam int MIN_GROUP = 2;
  localparam int MIN_DIMS  = 1;

  localparam logic [GS_W-1:0]   GS_RESET   = GS_W'(4);
  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_DIMS-1:0] crow_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam crow_t  ROW_MAX   = {NUM_DIMS{COORD_MAX}};
  localparam crow_t  ROW_MIN   = {NUM_DIMS{COORD_MIN}};

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_GROUP_SIZE  = 1'b0,
    REG_DIMS_IN_USE = 1'b1
  } reg_idx_t;

  // Item classes.
  typedef enum logic {
    OP_POINT = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic [GS_W-1:0]   group_size;
    logic [DIMS_W-1:0] dims_in_use;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [NUM_DIMS-1:0] dim_mask;
    logic [GS_W-1:0]   group_eff;
    crow_t             coord;
  } cmd_t;

  typedef struct packed {
    crow_t              low;
    crow_t              high;
    logic [LEVEL_W-1:0] tree_level;
    logic [INDEX_W-1:0] box_index;
    logic               last;
  } res_t;

endpackage

/* src/bbtb_fifo.sv */
// Small first-in first-out queue of flip-flops with a registered fill count.
module bbtb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/bbtb_front.sv */
// Front end: takes items, clamps the configuration and queues commands for the back end.
module bbtb_front #(
  parameter int MAX_GROUP = bbtb_pkg::MAX_GROUP_DEF,
  parameter int CMD_DEPTH = bbtb_pkg::CMD_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbtb_pkg::cfg_t      cfg,
  input  logic                push,
  output logic                full,
  input  bbtb_pkg::crow_t     coord,
  input  logic                end_of_set,
  output logic                cmd_valid,
  output bbtb_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  bbtb_pkg::cmd_t                   cmd_in;
  logic [bbtb_pkg::GS_W-1:0]        group_eff;
  logic [bbtb_pkg::DIMS_W-1:0]      dims_eff;
  logic [bbtb_pkg::NUM_DIMS-1:0]    dim_mask;
  logic [$bits(bbtb_pkg::cmd_t)-1:0] cmd_vec;
  logic                             cmd_empty;

  // Clamp the registers into their working ranges.
  always_comb begin
    if (cfg.group_size < bbtb_pkg::GS_W'(bbtb_pkg::MIN_GROUP)) begin
      group_eff = bbtb_pkg::GS_W'(bbtb_pkg::MIN_GROUP);
    end else if (cfg.group_size > bbtb_pkg::GS_W'(MAX_GROUP)) begin
      group_eff = bbtb_pkg::GS_W'(MAX_GROUP);
    end else begin
      group_eff = cfg.group_size;
    end
    if (cfg.dims_in_use < bbtb_pkg::DIMS_W'(bbtb_pkg::MIN_DIMS)) begin
      dims_eff = bbtb_pkg::DIMS_W'(bbtb_pkg::MIN_DIMS);
    end else if (cfg.dims_in_use > bbtb_pkg::DIMS_W'(bbtb_pkg::NUM_DIMS)) begin
      dims_eff = bbtb_pkg::DIMS_W'(bbtb_pkg::NUM_DIMS);
    end else begin
      dims_eff = cfg.dims_in_use;
    end
    for (int d = 0; d < bbtb_pkg::NUM_DIMS; d++) begin
      dim_mask[d] = bbtb_pkg::DIMS_W'(d) < dims_eff;
    end
  end

  // Classify the item as a point or a flush request.
  always_comb begin
    cmd_in.op        = end_of_set ? bbtb_pkg::OP_FLUSH : bbtb_pkg::OP_POINT;
    cmd_in.dim_mask  = dim_mask;
    cmd_in.group_eff = group_eff;
    cmd_in.coord     = coord;
  end

  bbtb_fifo #(
    .WIDTH ($bits(bbtb_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_vec),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = cmd_vec;

endmodule

/* src/bbtb_back.sv */
// Back end: level accumulators, cascade and flush sequencer, and the result queue.
module bbtb_back #(
  parameter int MAX_LEVELS = bbtb_pkg::MAX_LEVELS_DEF,
  parameter int MAX_GROUP  = bbtb_pkg::MAX_GROUP_DEF,
  parameter int RES_DEPTH  = bbtb_pkg::RES_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  bbtb_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            res_empty,
  input  logic            res_pop,
  output bbtb_pkg::res_t  res
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int ND    = bbtb_pkg::NUM_DIMS;
  localparam int IDX_W = bbtb_pkg::INDEX_W;
  localparam int LEV_W = bbtb_pkg::LEVEL_W;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(MAX_LEVELS - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CASCADE = 4'b0010,
    ST_FLUSH   = 4'b0100,
    ST_ROOT    = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [LVL_W-1:0]     lv_r, lv_nxt;
  bbtb_pkg::crow_t      carry_lo_r, carry_lo_nxt;
  bbtb_pkg::crow_t      carry_hi_r, carry_hi_nxt;
  logic                 carry_pend_r, carry_pend_nxt;
  logic [ND-1:0]        mask_r, mask_nxt;
  logic [CNT_W-1:0]     gs_r, gs_nxt;
  bbtb_pkg::crow_t      acc_lo_r [MAX_LEVELS];
  bbtb_pkg::crow_t      acc_lo_nxt [MAX_LEVELS];
  bbtb_pkg::crow_t      acc_hi_r [MAX_LEVELS];
  bbtb_pkg::crow_t      acc_hi_nxt [MAX_LEVELS];
  logic [CNT_W-1:0]     cnt_r [MAX_LEVELS];
  logic [CNT_W-1:0]     cnt_nxt [MAX_LEVELS];
  logic [IDX_W-1:0]     box_cnt_r [MAX_LEVELS];
  logic [IDX_W-1:0]     box_cnt_nxt [MAX_LEVELS];
  bbtb_pkg::crow_t      ovl_lo_r, ovl_lo_nxt;
  bbtb_pkg::crow_t      ovl_hi_r, ovl_hi_nxt;

  logic [MAX_LEVELS-1:0] box_nz;
  logic [MAX_LEVELS-1:0] lvl_nz;
  logic [LVL_W-1:0]      top_lv;
  logic [LVL_W-1:0]      rd_lv;
  logic                  above;
  logic                  use_carry;
  bbtb_pkg::crow_t       eff_lo, eff_hi;
  logic [CNT_W-1:0]      eff_cnt;
  logic [IDX_W-1:0]      box_idx;
  logic                  close_grp;
  logic                  drop_partial;
  logic                  emit_root;

  logic                  res_wr;
  logic                  res_full;
  bbtb_pkg::res_t        res_d;
  logic [$bits(bbtb_pkg::res_t)-1:0] res_vec;

  // Occupancy flags of the levels, the highest level holding a box, and
  // whether anything sits above the level being visited.
  always_comb begin
    top_lv = '0;
    above  = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      box_nz[i] = (box_cnt_r[i] != '0);
      lvl_nz[i] = (cnt_r[i] != '0) || box_nz[i];
      if (box_nz[i]) begin
        top_lv = LVL_W'(i);
      end
      if ((LVL_W'(i) > lv_r) && lvl_nz[i]) begin
        above = 1'b1;
      end
    end
  end

  // One level read per cycle; the root step reads the box count of the top level.
  assign rd_lv   = (state_r == ST_ROOT) ? top_lv : lv_r;
  assign box_idx = box_cnt_r[rd_lv];

  // Fold the carried box into the accumulator of the current level.
  assign use_carry = (state_r == ST_CASCADE) || carry_pend_r;
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      eff_lo[d] = acc_lo_r[lv_r][d];
      eff_hi[d] = acc_hi_r[lv_r][d];
      if (use_carry && mask_r[d]) begin
        if ($signed(carry_lo_r[d]) < $signed(acc_lo_r[lv_r][d])) begin
          eff_lo[d] = carry_lo_r[d];
        end
        if ($signed(carry_hi_r[d]) > $signed(acc_hi_r[lv_r][d])) begin
          eff_hi[d] = carry_hi_r[d];
        end
      end
    end
  end
  assign eff_cnt   = cnt_r[lv_r] + CNT_W'(use_carry);
  assign close_grp = (eff_cnt >= gs_r);

  // A lone partial at the top of a flush repeats a box already given.
  assign drop_partial = (lv_r != '0) && (box_idx == '0) &&
                        (eff_cnt == CNT_W'(1)) && !above;

  // Result formation; unused dimensions read as zero.
  assign emit_root = (state_r == ST_ROOT);
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      res_d.low[d]  = '0;
      res_d.high[d] = '0;
      if (mask_r[d]) begin
        res_d.low[d]  = emit_root ? ovl_lo_r[d] : eff_lo[d];
        res_d.high[d] = emit_root ? ovl_hi_r[d] : eff_hi[d];
      end
    end
    if (emit_root) begin
      res_d.tree_level = LEV_W'(top_lv) + LEV_W'(1);
      res_d.box_index  = (box_idx > IDX_W'(1)) ? box_idx : '0;
      res_d.last       = 1'b1;
    end else begin
      res_d.tree_level = LEV_W'(lv_r) + LEV_W'(1);
      res_d.box_index  = box_idx;
      res_d.last       = 1'b0;
    end
  end

  // Sequencer: a point climbs one level a cycle while it closes groups and the
  // result queue has room; a flush visits the levels upward, then the root box.
  always_comb begin
    state_nxt      = state_r;
    lv_nxt         = lv_r;
    carry_lo_nxt   = carry_lo_r;
    carry_hi_nxt   = carry_hi_r;
    carry_pend_nxt = carry_pend_r;
    mask_nxt       = mask_r;
    gs_nxt         = gs_r;
    acc_lo_nxt     = acc_lo_r;
    acc_hi_nxt     = acc_hi_r;
    cnt_nxt        = cnt_r;
    box_cnt_nxt    = box_cnt_r;
    ovl_lo_nxt     = ovl_lo_r;
    ovl_hi_nxt     = ovl_hi_r;
    cmd_pop        = 1'b0;
    res_wr         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          mask_nxt       = cmd.dim_mask;
          gs_nxt         = cmd.group_eff[CNT_W-1:0];
          lv_nxt         = '0;
          carry_pend_nxt = 1'b0;
          if (cmd.op == bbtb_pkg::OP_POINT) begin
            carry_lo_nxt = cmd.coord;
            carry_hi_nxt = cmd.coord;
            for (int d = 0; d < ND; d++) begin
              if (cmd.dim_mask[d] && ($signed(cmd.coord[d]) < $signed(ovl_lo_r[d]))) begin
                ovl_lo_nxt[d] = cmd.coord[d];
              end
              if (cmd.dim_mask[d] && ($signed(cmd.coord[d]) > $signed(ovl_hi_r[d]))) begin
                ovl_hi_nxt[d] = cmd.coord[d];
              end
            end
            state_nxt = ST_CASCADE;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_CASCADE: begin
        if (!close_grp) begin
          acc_lo_nxt[lv_r] = eff_lo;
          acc_hi_nxt[lv_r] = eff_hi;
          cnt_nxt[lv_r]    = eff_cnt;
          state_nxt        = ST_IDLE;
        end else if (!res_full) begin
          res_wr               = 1'b1;
          box_cnt_nxt[lv_r]    = box_cnt_r[lv_r] + 1'b1;
          acc_lo_nxt[lv_r]     = bbtb_pkg::ROW_MAX;
          acc_hi_nxt[lv_r]     = bbtb_pkg::ROW_MIN;
          cnt_nxt[lv_r]        = '0;
          carry_lo_nxt         = eff_lo;
          carry_hi_nxt         = eff_hi;
          if (lv_r == LAST_LVL) begin
            state_nxt = ST_IDLE;
          end else begin
            lv_nxt = lv_r + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (eff_cnt == '0) begin
          if (lv_r == LAST_LVL) begin
            state_nxt = ST_ROOT;
          end else begin
            lv_nxt = lv_r + 1'b1;
          end
        end else if (drop_partial) begin
          state_nxt = ST_ROOT;
        end else if (!res_full) begin
          res_wr            = 1'b1;
          box_cnt_nxt[lv_r] = box_cnt_r[lv_r] + 1'b1;
          carry_lo_nxt      = eff_lo;
          carry_hi_nxt      = eff_hi;
          carry_pend_nxt    = 1'b1;
          if (lv_r == LAST_LVL) begin
            state_nxt = ST_ROOT;
          end else begin
            lv_nxt = lv_r + 1'b1;
          end
        end
      end

      ST_ROOT: begin
        if (!res_full) begin
          res_wr     = 1'b1;
          ovl_lo_nxt = bbtb_pkg::ROW_MAX;
          ovl_hi_nxt = bbtb_pkg::ROW_MIN;
          for (int i = 0; i < MAX_LEVELS; i++) begin
            acc_lo_nxt[i]  = bbtb_pkg::ROW_MAX;
            acc_hi_nxt[i]  = bbtb_pkg::ROW_MIN;
            cnt_nxt[i]     = '0;
            box_cnt_nxt[i] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lv_r         <= '0;
      carry_pend_r <= 1'b0;
      mask_r       <= '0;
      gs_r         <= '0;
      ovl_lo_r     <= bbtb_pkg::ROW_MAX;
      ovl_hi_r     <= bbtb_pkg::ROW_MIN;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        acc_lo_r[i]  <= bbtb_pkg::ROW_MAX;
        acc_hi_r[i]  <= bbtb_pkg::ROW_MIN;
        cnt_r[i]     <= '0;
        box_cnt_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      lv_r         <= lv_nxt;
      carry_pend_r <= carry_pend_nxt;
      mask_r       <= mask_nxt;
      gs_r         <= gs_nxt;
      ovl_lo_r     <= ovl_lo_nxt;
      ovl_hi_r     <= ovl_hi_nxt;
      acc_lo_r     <= acc_lo_nxt;
      acc_hi_r     <= acc_hi_nxt;
      cnt_r        <= cnt_nxt;
      box_cnt_r    <= box_cnt_nxt;
    end
  end

  // The carried box is payload and needs no reset.
  always_ff @(posedge clk) begin
    carry_lo_r <= carry_lo_nxt;
    carry_hi_r <= carry_hi_nxt;
  end

  // Result queue decouples the sequencer from the consumer.
  bbtb_fifo #(
    .WIDTH ($bits(bbtb_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_d),
    .full    (res_full),
    .rd_en   (res_pop),
    .rd_data (res_vec),
    .empty   (res_empty)
  );

  assign res = res_vec;

endmodule

/* src/bounding_box_tree_builder_unit.sv */
// The sequencer takes a point from the command queue and climbs the levels, giving a box at each
// level whose group it closes; an end-of-set item visits the levels upward and then gives the root.
// The command queue takes new items while the sequencer works and results wait in the result queue.
// Reset is synchronous and active low: it empties both queues, clears every level accumulator at
// once and sets group_size to 4 and dims_in_use to 2; no clearing pass follows.
module bounding_box_tree_builder_unit #(
  parameter int MAX_LEVELS = bbtb_pkg::MAX_LEVELS_DEF,
  parameter int MAX_GROUP  = bbtb_pkg::MAX_GROUP_DEF,
  parameter int CMD_DEPTH  = bbtb_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH  = bbtb_pkg::RES_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bbtb_pkg::ADDR_W-1:0]         paddr,
  input  logic [bbtb_pkg::DATA_W-1:0]         pwdata,
  output logic [bbtb_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // Input channel
  input  logic                                push,
  output logic                                full,
  input  logic signed [bbtb_pkg::COORD_W-1:0] in_coord_0,
  input  logic signed [bbtb_pkg::COORD_W-1:0] in_coord_1,
  input  logic signed [bbtb_pkg::COORD_W-1:0] in_coord_2,
  input  logic signed [bbtb_pkg::COORD_W-1:0] in_coord_3,
  input  logic                                in_end_of_set,
  // Result channel
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_low_0,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_high_0,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_low_1,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_high_1,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_low_2,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_high_2,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_low_3,
  output logic signed [bbtb_pkg::COORD_W-1:0] out_high_3,
  output logic [bbtb_pkg::LEVEL_W-1:0]        out_tree_level,
  output logic [bbtb_pkg::INDEX_W-1:0]        out_box_index,
  output logic                                out_last
);

  logic [bbtb_pkg::GS_W-1:0]   group_size_r, group_size_nxt;
  logic [bbtb_pkg::DIMS_W-1:0] dims_in_use_r, dims_in_use_nxt;
  bbtb_pkg::reg_idx_t          reg_idx;
  logic                        cfg_wr;
  bbtb_pkg::cfg_t              cfg;
  bbtb_pkg::crow_t             coord;
  logic                        cmd_valid;
  logic                        cmd_pop;
  bbtb_pkg::cmd_t              cmd;
  bbtb_pkg::res_t              res;

  // Configuration registers; a write transfer completes in the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bbtb_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    group_size_nxt  = group_size_r;
    dims_in_use_nxt = dims_in_use_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        bbtb_pkg::REG_GROUP_SIZE:  group_size_nxt  = pwdata[bbtb_pkg::GS_W-1:0];
        bbtb_pkg::REG_DIMS_IN_USE: dims_in_use_nxt = pwdata[bbtb_pkg::DIMS_W-1:0];
        default: begin
          group_size_nxt = group_size_r;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      bbtb_pkg::REG_GROUP_SIZE:  prdata = bbtb_pkg::DATA_W'(group_size_r);
      bbtb_pkg::REG_DIMS_IN_USE: prdata = bbtb_pkg::DATA_W'(dims_in_use_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r  <= bbtb_pkg::GS_RESET;
      dims_in_use_r <= bbtb_pkg::DIMS_RESET;
    end else begin
      group_size_r  <= group_size_nxt;
      dims_in_use_r <= dims_in_use_nxt;
    end
  end

  assign cfg.group_size  = group_size_r;
  assign cfg.dims_in_use = dims_in_use_r;

  assign coord[0] = in_coord_0;
  assign coord[1] = in_coord_1;
  assign coord[2] = in_coord_2;
  assign coord[3] = in_coord_3;

  bbtb_front #(
    .MAX_GROUP (MAX_GROUP),
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .coord      (coord),
    .end_of_set (in_end_of_set),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  bbtb_back #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_GROUP  (MAX_GROUP),
    .RES_DEPTH  (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign out_low_0      = res.low[0];
  assign out_high_0     = res.high[0];
  assign out_low_1      = res.low[1];
  assign out_high_1     = res.high[1];
  assign out_low_2      = res.low[2];
  assign out_high_2     = res.high[2];
  assign out_low_3      = res.low[3];
  assign out_high_3     = res.high[3];
  assign out_tree_level = res.tree_level;
  assign out_box_index  = res.box_index;
  assign out_last       = res.last;

  // The sequencer only takes a command that the front end has queued.
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // Every waiting result carries a level inside the tree.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_tree_level != '0) &&
               (out_tree_level <= bbtb_pkg::LEVEL_W'(MAX_LEVELS)))
    else $error("result level outside the tree");

  // A box built from points never has its first-dimension low above its high.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> ($signed(out_low_0) <= $signed(out_high_0)))
    else $error("box low exceeds high in the first dimension");

endmodule

/* tb/tb_bounding_box_tree_builder_unit.sv */
// Self-checking testbench of the bounding box tree builder: a directed table, then random point sets.
module tb_bounding_box_tree_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS      = bbtb_pkg::MAX_LEVELS_DEF;
  localparam int SETTLE      = 4 * (LEVELS + 2);
  localparam int QUIET_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int DEEP_BURST  = 40;

  localparam bbtb_pkg::coord_t HI   = bbtb_pkg::COORD_MAX;
  localparam bbtb_pkg::coord_t LO   = bbtb_pkg::COORD_MIN;
  localparam bbtb_pkg::coord_t Z    = '0;
  localparam bbtb_pkg::coord_t M1   = 32'hFFFF_FFFF;
  localparam bbtb_pkg::coord_t ONEQ = 32'h0001_0000;
  localparam bbtb_pkg::crow_t  ZROW = '0;
  localparam bbtb_pkg::res_t   NO_BOX = '0;
  // Root of an empty set with the reset setting of two dimensions.
  localparam bbtb_pkg::res_t   EMPTY_ROOT = '{{Z, Z, HI, HI}, {Z, Z, LO, LO}, 4'd1, 24'd0, 1'b1};
  // First level-1 box of one dimension spanning the whole coordinate range.
  localparam bbtb_pkg::res_t   FULL_SPAN  = '{{Z, Z, Z, LO}, {Z, Z, Z, HI}, 4'd1, 24'd0, 1'b0};

  typedef enum logic [1:0] {STEP_POINT, STEP_FLUSH, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t                  kind;
    bbtb_pkg::reg_idx_t          reg_sel;
    logic [bbtb_pkg::DATA_W-1:0] wdata;
    bbtb_pkg::crow_t             pt;
    logic                        typed;
    bbtb_pkg::res_t              want;
  } step_t;

  localparam int N_STEPS = 27;

  logic clk;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bbtb_pkg::ADDR_W-1:0] paddr = '0;
  logic [bbtb_pkg::DATA_W-1:0] pwdata = '0;
  logic [bbtb_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  bbtb_pkg::coord_t in_coord_0 = '0;
  bbtb_pkg::coord_t in_coord_1 = '0;
  bbtb_pkg::coord_t in_coord_2 = '0;
  bbtb_pkg::coord_t in_coord_3 = '0;
  logic in_end_of_set = 1'b0;
  logic empty;
  logic pop = 1'b0;
  bbtb_pkg::coord_t out_low_0, out_high_0, out_low_1, out_high_1;
  bbtb_pkg::coord_t out_low_2, out_high_2, out_low_3, out_high_3;
  logic [bbtb_pkg::LEVEL_W-1:0] out_tree_level;
  logic [bbtb_pkg::INDEX_W-1:0] out_box_index;
  logic out_last;

  // Mirror of the registers and of the tree state.
  logic [bbtb_pkg::GS_W-1:0]    cfg_group;
  logic [bbtb_pkg::DIMS_W-1:0]  cfg_dims;
  bbtb_pkg::crow_t              acc_lo [LEVELS];
  bbtb_pkg::crow_t              acc_hi [LEVELS];
  logic [bbtb_pkg::GS_W-1:0]    members [LEVELS];
  logic [bbtb_pkg::INDEX_W-1:0] boxes_made [LEVELS];
  bbtb_pkg::crow_t              span_lo;
  bbtb_pkg::crow_t              span_hi;
  bbtb_pkg::res_t               boxes_due [$];

  step_t script [N_STEPS];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bad_boxes = 0;
  int boxes_checked = 0;
  int deepest = 0;
  int points_sent = 0;
  int flushes_sent = 0;
  int writes_done = 0;
  int input_stalls = 0;

  bounding_box_tree_builder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .in_coord_0    (in_coord_0),
    .in_coord_1    (in_coord_1),
    .in_coord_2    (in_coord_2),
    .in_coord_3    (in_coord_3),
    .in_end_of_set (in_end_of_set),
    .empty         (empty),
    .pop           (pop),
    .out_low_0     (out_low_0),
    .out_high_0    (out_high_0),
    .out_low_1     (out_low_1),
    .out_high_1    (out_high_1),
    .out_low_2     (out_low_2),
    .out_high_2    (out_high_2),
    .out_low_3     (out_low_3),
    .out_high_3    (out_high_3),
    .out_tree_level(out_tree_level),
    .out_box_index (out_box_index),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Register values are clamped into their legal ranges before use.
  function automatic int eff_dims();
    if (cfg_dims < bbtb_pkg::MIN_DIMS) return bbtb_pkg::MIN_DIMS;
    if (cfg_dims > bbtb_pkg::NUM_DIMS) return bbtb_pkg::NUM_DIMS;
    return int'(cfg_dims);
  endfunction

  function automatic int eff_group();
    if (cfg_group < bbtb_pkg::MIN_GROUP) return bbtb_pkg::MIN_GROUP;
    if (cfg_group > bbtb_pkg::MAX_GROUP_DEF) return bbtb_pkg::MAX_GROUP_DEF;
    return int'(cfg_group);
  endfunction

  function automatic void clear_level(int lv);
    acc_lo[lv] = bbtb_pkg::ROW_MAX;
    acc_hi[lv] = bbtb_pkg::ROW_MIN;
    members[lv] = '0;
  endfunction

  function automatic void clear_tree();
    for (int lv = 0; lv < LEVELS; lv++) begin
      clear_level(lv);
      boxes_made[lv] = '0;
    end
    span_lo = bbtb_pkg::ROW_MAX;
    span_hi = bbtb_pkg::ROW_MIN;
  endfunction

  // Unused dimensions of a box read as zero.
  function automatic void queue_box(bbtb_pkg::crow_t lo, bbtb_pkg::crow_t hi, int dims, int lvl,
                                    logic [bbtb_pkg::INDEX_W-1:0] idx, logic is_root);
    bbtb_pkg::res_t b;
    b = '0;
    for (int d = 0; d < dims; d++) begin
      b.low[d] = lo[d];
      b.high[d] = hi[d];
    end
    b.tree_level = bbtb_pkg::LEVEL_W'(lvl);
    b.box_index = idx;
    b.last = is_root;
    boxes_due.insert(boxes_due.size(), b);
  endfunction

  function automatic void fold_into(int lv, bbtb_pkg::crow_t lo, bbtb_pkg::crow_t hi, int dims);
    for (int d = 0; d < dims; d++) begin
      if ($signed(lo[d]) < $signed(acc_lo[lv][d])) acc_lo[lv][d] = lo[d];
      if ($signed(hi[d]) > $signed(acc_hi[lv][d])) acc_hi[lv][d] = hi[d];
    end
    members[lv] = members[lv] + 1'b1;
  endfunction

  // Give out the box gathered at one level and leave it in lo/hi for the level above.
  function automatic void close_level(int lv, int dims, output bbtb_pkg::crow_t lo,
                                      output bbtb_pkg::crow_t hi);
    lo = acc_lo[lv];
    hi = acc_hi[lv];
    queue_box(lo, hi, dims, lv + 1, boxes_made[lv], 1'b0);
    boxes_made[lv] = boxes_made[lv] + 1'b1;
    clear_level(lv);
  endfunction

  function automatic void predict_point(bbtb_pkg::crow_t pt);
    int dims;
    int gs;
    bbtb_pkg::crow_t lo;
    bbtb_pkg::crow_t hi;
    dims = eff_dims();
    gs = eff_group();
    lo = pt;
    hi = pt;
    for (int d = 0; d < dims; d++) begin
      if ($signed(pt[d]) < $signed(span_lo[d])) span_lo[d] = pt[d];
      if ($signed(pt[d]) > $signed(span_hi[d])) span_hi[d] = pt[d];
    end
    // A completed group cascades upward; the top level is not folded further.
    for (int lv = 0; lv < LEVELS; lv++) begin
      fold_into(lv, lo, hi, dims);
      if (members[lv] < gs) break;
      close_level(lv, dims, lo, hi);
    end
  endfunction

  function automatic void predict_flush();
    int dims;
    int top;
    bit above;
    logic [bbtb_pkg::INDEX_W-1:0] idx;
    bbtb_pkg::crow_t lo;
    bbtb_pkg::crow_t hi;
    dims = eff_dims();
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (members[lv] == 0) continue;
      above = 1'b0;
      for (int u = lv + 1; u < LEVELS; u++)
        if (members[u] != 0 || boxes_made[u] != 0) above = 1'b1;
      // A lone partial box with nothing else at or above its level was given already.
      if (lv > 0 && boxes_made[lv] == 0 && members[lv] == 1 && !above) begin
        clear_level(lv);
        break;
      end
      close_level(lv, dims, lo, hi);
      if (lv + 1 < LEVELS) fold_into(lv + 1, lo, hi, dims);
    end
    // The root sits at the highest level holding a box.
    top = 0;
    idx = '0;
    for (int lv = 0; lv < LEVELS; lv++)
      if (boxes_made[lv] != 0) top = lv;
    if (boxes_made[top] > 1) idx = boxes_made[top];
    queue_box(span_lo, span_hi, dims, top + 1, idx, 1'b1);
    clear_tree();
  endfunction

  function automatic bbtb_pkg::coord_t rand_coord();
    case ($urandom_range(7))
      0: return HI;
      1: return LO;
      2: return bbtb_pkg::coord_t'($urandom_range(2)) - 32'sd1;
      3: return bbtb_pkg::coord_t'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      default: return bbtb_pkg::coord_t'($urandom());
    endcase
  endfunction

  function automatic bbtb_pkg::crow_t rand_row();
    bbtb_pkg::crow_t r;
    for (int d = 0; d < bbtb_pkg::NUM_DIMS; d++) r[d] = rand_coord();
    return r;
  endfunction

  // Offer one item after a random gap and update the prediction on its transfer.
  task automatic offer(bbtb_pkg::op_t op, bbtb_pkg::crow_t pt, logic typed,
                       bbtb_pkg::res_t want);
    int known;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_end_of_set <= op;
    in_coord_0 <= pt[0];
    in_coord_1 <= pt[1];
    in_coord_2 <= pt[2];
    in_coord_3 <= pt[3];
    do @(posedge clk); while (full);
    known = boxes_due.size();
    if (op == bbtb_pkg::OP_FLUSH) begin
      predict_flush();
      flushes_sent++;
    end else begin
      predict_point(pt);
      points_sent++;
    end
    if (typed) begin
      while (boxes_due.size() > known) void'(boxes_due.pop_back());
      boxes_due.insert(boxes_due.size(), want);
    end
  endtask

  // Wait until every expected box has come and the block has had time to finish silent items.
  task automatic settle();
    push <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(bbtb_pkg::reg_idx_t r, logic [bbtb_pkg::DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bbtb_pkg::ADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (r == bbtb_pkg::REG_GROUP_SIZE) cfg_group = v[bbtb_pkg::GS_W-1:0];
    else cfg_dims = v[bbtb_pkg::DIMS_W-1:0];
    writes_done++;
    @(posedge clk);
  endtask

  // Random sets of points, mostly closed by an end-of-set item, with new settings now and then.
  task automatic run_phase(int n_items, int snd_pct, int rcv_pct);
    int sent;
    int set_len;
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        settle();
        write_reg(bbtb_pkg::REG_GROUP_SIZE,
                  ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2, 16));
        write_reg(bbtb_pkg::REG_DIMS_IN_USE,
                  ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1, 4));
      end
      set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                         : $urandom_range(1, 3 * eff_group());
      if (set_len > n_items - sent) set_len = n_items - sent;
      repeat (set_len) offer(bbtb_pkg::OP_POINT, rand_row(), 1'b0, NO_BOX);
      sent += set_len;
      if ($urandom_range(99) < 85) begin
        offer(bbtb_pkg::OP_FLUSH, rand_row(), 1'b0, NO_BOX);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, a long hold-off on request, and the check of every transfer.
  always @(posedge clk) begin : take_boxes
    bbtb_pkg::res_t got;
    bbtb_pkg::res_t want;
    bit bad;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.low = {out_low_3, out_low_2, out_low_1, out_low_0};
        got.high = {out_high_3, out_high_2, out_high_1, out_high_0};
        got.tree_level = out_tree_level;
        got.box_index = out_box_index;
        got.last = out_last;
        boxes_checked++;
        if (int'(got.tree_level) > deepest) deepest = int'(got.tree_level);
        if (boxes_due.size() == 0) begin
          if (bad_boxes < REPORT_MAX)
            $display("unexpected box: level %0d index %0d", got.tree_level, got.box_index);
          bad_boxes++;
        end else begin
          want = boxes_due.pop_front();
          bad = (got.tree_level !== want.tree_level) || (got.box_index !== want.box_index) ||
                (got.last !== want.last);
          for (int d = 0; d < bbtb_pkg::NUM_DIMS; d++)
            if (got.low[d] !== want.low[d] || got.high[d] !== want.high[d]) bad = 1'b1;
          if (bad) begin
            if (bad_boxes < REPORT_MAX) begin
              $display("box mismatch: expected level %0d index %0d last %0b low %h high %h",
                       want.tree_level, want.box_index, want.last, want.low, want.high);
              $display("              actual   level %0d index %0d last %0b low %h high %h",
                       got.tree_level, got.box_index, got.last, got.low, got.high);
            end
            bad_boxes++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n && push && full) input_stalls++;
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    script = '{
      // Empty set straight after reset.
      '{STEP_FLUSH, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b1, EMPTY_ROOT},
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'd2, ZROW, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_DIMS_IN_USE, 32'd1, ZROW, 1'b0, NO_BOX},
      // Opposite extremes in one dimension; the other coordinates are ignored.
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {HI, LO, M1, LO}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {LO, HI, Z, HI}, 1'b1, FULL_SPAN},
      // The lone level-2 partial is the box just given, so only the root follows.
      '{STEP_FLUSH, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'd16, ZROW, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_DIMS_IN_USE, 32'd4, ZROW, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {HI, HI, HI, HI}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {LO, LO, LO, LO}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {ONEQ, Z, M1, Z}, 1'b0, NO_BOX},
      '{STEP_FLUSH, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b0, NO_BOX},
      // Registers below their legal ranges.
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_DIMS_IN_USE, 32'd0, ZROW, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {Z, Z, Z, M1}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {M1, M1, M1, ONEQ}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {HI, LO, HI, LO}, 1'b0, NO_BOX},
      '{STEP_FLUSH, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b0, NO_BOX},
      // Registers above their legal ranges, upper data bits set.
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'hFFFF_FFFF, ZROW, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_DIMS_IN_USE, 32'hFFFF_FFFF, ZROW, 1'b0, NO_BOX},
      // Group size lowered while a group is partly filled.
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'd4, ZROW, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {Z, ONEQ, LO, HI}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {M1, HI, Z, Z}, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {LO, Z, ONEQ, M1}, 1'b0, NO_BOX},
      '{STEP_WRITE, bbtb_pkg::REG_GROUP_SIZE, 32'd2, ZROW, 1'b0, NO_BOX},
      '{STEP_POINT, bbtb_pkg::REG_GROUP_SIZE, 32'd0, {ONEQ, M1, HI, LO}, 1'b0, NO_BOX},
      '{STEP_FLUSH, bbtb_pkg::REG_GROUP_SIZE, 32'd0, ZROW, 1'b0, NO_BOX}
    };
    cfg_group = bbtb_pkg::GS_RESET;
    cfg_dims = bbtb_pkg::DIMS_RESET;
    clear_tree();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (script[i]) begin
      case (script[i].kind)
        STEP_WRITE: begin
          settle();
          write_reg(script[i].reg_sel, script[i].wdata);
        end
        STEP_FLUSH: offer(bbtb_pkg::OP_FLUSH, script[i].pt, script[i].typed, script[i].want);
        default:    offer(bbtb_pkg::OP_POINT, script[i].pt, script[i].typed, script[i].want);
      endcase
    end

    // Random sets under the different idling patterns.
    run_phase(10, 0, 0);
    run_phase(10, 78, 0);
    run_phase(10, 0, 78);

    // One deep set of pairs that climbs to the top level. At its start the result side
    // holds off while points keep coming, so both queues fill and the input stalls.
    settle();
    write_reg(bbtb_pkg::REG_GROUP_SIZE, 32'd2);
    write_reg(bbtb_pkg::REG_DIMS_IN_USE, $urandom_range(1, 4));
    send_idle_pct = 0;
    recv_stall_pct = 27;
    hold_left = HOLD_CYCLES;
    repeat (DEEP_BURST) offer(bbtb_pkg::OP_POINT, rand_row(), 1'b0, NO_BOX);
    send_idle_pct = 27;
    repeat (2 ** LEVELS - DEEP_BURST) offer(bbtb_pkg::OP_POINT, rand_row(), 1'b0, NO_BOX);
    offer(bbtb_pkg::OP_FLUSH, ZROW, 1'b0, NO_BOX);

    run_phase(10, 27, 27);
    settle();

    $display("Run summary: %0d points and %0d end-of-set items, %0d boxes checked, deepest level %0d.",
             points_sent, flushes_sent, boxes_checked, deepest);
    $display("%0d register writes, %0d cycles with the input held off, %0d mismatches.",
             writes_done, input_stalls, bad_boxes);
    if (bad_boxes == 0 && boxes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
